// File: rtl/drlh_pkg.sv
// shared types and constants for the double rolling hash / lcp core
// no dependencies
package drlh_pkg;

  localparam int POS_W   = 17;
  localparam int RES_W   = 31;
  localparam int ENT_W   = 2 * RES_W;
  localparam int MAX_LEN = 65536;
  localparam int DEPTH   = MAX_LEN + 1;
  localparam int CNT_W   = 5;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [RES_W-1:0] res_t;
  typedef logic [ENT_W-1:0] ent_t;

  localparam res_t P_A    = 31'd2034452107;
  localparam res_t P_B    = 31'd2013074419;
  localparam res_t BASE_A = 31'd137;
  localparam res_t BASE_B = 31'd149;

  // multiplier bit counts for the shift-add modular multiply
  localparam logic [CNT_W-1:0] MUL_BITS_BASE = 5'd8;
  localparam logic [CNT_W-1:0] MUL_BITS_FULL = 5'd31;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_HASH   = 2'd1,
    MODE_LCP    = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] symbol;
    pos_t       first_pos;
    pos_t       second_pos;
    logic       fp_gt_sp;
    logic       fp_eq_sp;
  } item_t;

endpackage

// File: rtl/drlh_front.sv
// front end: input handshake and item classification
// depends on drlh_pkg
module drlh_front (
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [47:0]     in_tdata,   // symbol, first_pos, second_pos
  input  logic [1:0]      in_tuser,   // mode
  input  logic            fill_busy,
  input  logic            q_ready,
  output logic            q_valid,
  output drlh_pkg::item_t q_item
);
  import drlh_pkg::*;

  pos_t fp;
  pos_t sp;

  assign fp = in_tdata[24:8];
  assign sp = in_tdata[41:25];

  // no transfers while the power table is being built
  assign in_tready = q_ready & ~fill_busy;
  assign q_valid   = in_tvalid & ~fill_busy;

  always_comb begin
    q_item.mode       = mode_t'(in_tuser);
    q_item.symbol     = in_tdata[7:0];
    q_item.first_pos  = fp;
    q_item.second_pos = sp;
    q_item.fp_gt_sp   = (fp > sp);
    q_item.fp_eq_sp   = (fp == sp);
  end

endmodule

// File: rtl/drlh_queue.sv
// two-entry queue between front end and back end
// depends on drlh_pkg
module drlh_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  drlh_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_pop,
  output drlh_pkg::item_t rd_item
);
  import drlh_pkg::*;

  item_t      slot_r [0:1];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_item  = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_pop & rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_rd) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/drlh_mulmod.sv
// iterative modular multiply-add: (x*y + z) mod p, one multiplier bit per cycle
// depends on drlh_pkg
module drlh_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  drlh_pkg::res_t             x,
  input  drlh_pkg::res_t             y,
  input  drlh_pkg::res_t             z,
  input  drlh_pkg::res_t             p,
  input  logic [drlh_pkg::CNT_W-1:0] nbits,
  output drlh_pkg::res_t             res,
  output logic                       done
);
  import drlh_pkg::*;

  typedef enum logic [1:0] {MM_IDLE, MM_RUN, MM_ADDZ} mm_state_t;

  mm_state_t        state_r;
  res_t             acc_r;
  res_t             x_r;
  res_t             y_r;
  res_t             z_r;
  res_t             res_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [RES_W:0] p_ext;
  logic [RES_W:0] dbl;
  logic [RES_W:0] dbl_red;
  logic [RES_W:0] sum;
  logic [RES_W:0] sum_red;
  logic [RES_W:0] zsum;
  logic [RES_W:0] zsum_red;

  always_comb begin
    p_ext    = {1'b0, p};
    dbl      = {acc_r, 1'b0};
    dbl_red  = (dbl >= p_ext) ? dbl - p_ext : dbl;
    sum      = {1'b0, dbl_red[RES_W-1:0]} + {1'b0, (y_r[cnt_r] ? x_r : '0)};
    sum_red  = (sum >= p_ext) ? sum - p_ext : sum;
    zsum     = {1'b0, acc_r} + {1'b0, z_r};
    zsum_red = (zsum >= p_ext) ? zsum - p_ext : zsum;
  end

  assign res  = res_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MM_IDLE: begin
          if (start) begin
            x_r     <= x;
            y_r     <= y;
            z_r     <= z;
            acc_r   <= '0;
            cnt_r   <= nbits - CNT_W'(1);
            state_r <= MM_RUN;
          end
        end
        MM_RUN: begin
          acc_r <= sum_red[RES_W-1:0];
          if (cnt_r == '0) begin
            state_r <= MM_ADDZ;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        MM_ADDZ: begin
          res_r   <= zsum_red[RES_W-1:0];
          done_r  <= 1'b1;
          state_r <= MM_IDLE;
        end
        default: state_r <= MM_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/drlh_back.sv
// back end: prefix and power stores, command sequencer, result register
// depends on drlh_pkg and drlh_mulmod
module drlh_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  drlh_pkg::item_t q_item,
  output logic            fill_busy,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [79:0]     out_tdata,
  output logic [1:0]      out_tuser
);
  import drlh_pkg::*;

  typedef enum logic [3:0] {
    BK_FILL_WR, BK_FILL_MUL, BK_IDLE, BK_APP_WT, BK_APP_MUL,
    BK_LCP, BK_SH_L, BK_SH_R, BK_SH_GO, BK_SH_MUL
  } bk_state_t;

  bk_state_t state_r;
  pos_t      len_r;
  pos_t      k_r;
  res_t      cur_a_r;
  res_t      cur_b_r;
  item_t     item_r;
  pos_t      lo_r;
  pos_t      hi_r;
  pos_t      mid_r;
  pos_t      sh_l_r;
  pos_t      sh_r_r;
  logic      phase_r;
  ent_t      pre_l_r;
  ent_t      pow_v_r;
  ent_t      h1_r;
  logic      out_valid_r;
  logic [62:0] out_hash_r;
  pos_t      out_mlen_r;
  logic [1:0] out_status_r;

  // stores
  ent_t pre_mem [0:DEPTH-1];
  ent_t pow_mem [0:DEPTH-1];
  ent_t pre_q_r;
  ent_t pow_q_r;
  logic pre_zero_r;
  pos_t pre_raddr;
  pos_t pow_raddr;
  logic pre_we;
  pos_t pre_waddr;
  logic pow_we;
  ent_t pre_rd;

  // multiply units
  logic             mm_start;
  res_t             mm_xa, mm_xb, mm_ya, mm_yb, mm_za, mm_zb;
  logic [CNT_W-1:0] mm_nbits;
  res_t             res_a, res_b;
  logic             done_a, done_b;
  ent_t             mm_pair;

  logic [POS_W:0] mid_sum;
  pos_t           max_pos;

  assign pre_rd   = pre_zero_r ? '0 : pre_q_r;
  assign mm_pair  = {res_a, res_b};
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + (POS_W+1)'(1);
  assign max_pos  = q_item.fp_gt_sp ? q_item.first_pos : q_item.second_pos;
  assign q_pop    = (state_r == BK_IDLE) && q_valid && !out_valid_r;
  assign fill_busy = (state_r == BK_FILL_WR) || (state_r == BK_FILL_MUL);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mlen_r, out_hash_r};
  assign out_tuser  = out_status_r;

  always_comb begin
    pre_raddr = len_r;
    pow_raddr = sh_r_r - sh_l_r;
    case (state_r)
      BK_SH_L: pre_raddr = sh_l_r;
      BK_SH_R: pre_raddr = sh_r_r;
      default: pre_raddr = len_r;
    endcase
    pre_we    = (state_r == BK_APP_MUL) && done_a;
    pre_waddr = len_r + POS_W'(1);
    pow_we    = (state_r == BK_FILL_WR);
  end

  always_ff @(posedge clk) begin
    if (pre_we) begin
      pre_mem[pre_waddr] <= mm_pair;
    end
    pre_q_r    <= pre_mem[pre_raddr];
    pre_zero_r <= (pre_raddr == '0);
  end

  always_ff @(posedge clk) begin
    if (pow_we) begin
      pow_mem[k_r] <= {cur_a_r, cur_b_r};
    end
    pow_q_r <= pow_mem[pow_raddr];
  end

  always_comb begin
    mm_start = 1'b0;
    mm_xa    = cur_a_r;
    mm_xb    = cur_b_r;
    mm_ya    = BASE_A;
    mm_yb    = BASE_B;
    mm_za    = '0;
    mm_zb    = '0;
    mm_nbits = MUL_BITS_BASE;
    case (state_r)
      BK_FILL_WR: mm_start = (k_r != POS_W'(MAX_LEN));
      BK_APP_WT: begin
        mm_start = 1'b1;
        mm_xa    = pre_rd[ENT_W-1:RES_W];
        mm_xb    = pre_rd[RES_W-1:0];
        mm_za    = {23'd0, item_r.symbol};
        mm_zb    = {23'd0, item_r.symbol};
      end
      BK_SH_GO: begin
        mm_start = 1'b1;
        mm_xa    = pre_l_r[ENT_W-1:RES_W];
        mm_xb    = pre_l_r[RES_W-1:0];
        mm_ya    = pow_v_r[ENT_W-1:RES_W];
        mm_yb    = pow_v_r[RES_W-1:0];
        mm_za    = pre_rd[ENT_W-1:RES_W];
        mm_zb    = pre_rd[RES_W-1:0];
        mm_nbits = MUL_BITS_FULL;
      end
      default: mm_start = 1'b0;
    endcase
  end

  drlh_mulmod u_mul_a (
    .clk(clk), .rst_n(rst_n), .start(mm_start),
    .x(mm_xa), .y(mm_ya), .z(mm_za), .p(P_A), .nbits(mm_nbits),
    .res(res_a), .done(done_a)
  );

  drlh_mulmod u_mul_b (
    .clk(clk), .rst_n(rst_n), .start(mm_start),
    .x(mm_xb), .y(mm_yb), .z(mm_zb), .p(P_B), .nbits(mm_nbits),
    .res(res_b), .done(done_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL_WR;
      len_r       <= '0;
      k_r         <= '0;
      cur_a_r     <= P_A - RES_W'(1);
      cur_b_r     <= P_B - RES_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        BK_FILL_WR: begin
          if (k_r == POS_W'(MAX_LEN)) begin
            state_r <= BK_IDLE;
          end else begin
            state_r <= BK_FILL_MUL;
          end
        end
        BK_FILL_MUL: begin
          if (done_a && done_b) begin
            cur_a_r <= res_a;
            cur_b_r <= res_b;
            k_r     <= k_r + POS_W'(1);
            state_r <= BK_FILL_WR;
          end
        end
        BK_IDLE: begin
          if (q_pop) begin
            item_r       <= q_item;
            out_hash_r   <= '0;
            out_mlen_r   <= '0;
            out_status_r <= ST_OK;
            case (q_item.mode)
              MODE_APPEND: begin
                if (len_r == POS_W'(MAX_LEN)) begin
                  out_mlen_r   <= len_r;
                  out_status_r <= ST_FULL;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= BK_APP_WT;
                end
              end
              MODE_HASH: begin
                if (q_item.fp_gt_sp || (q_item.second_pos > len_r)) begin
                  out_status_r <= ST_RANGE;
                  out_valid_r  <= 1'b1;
                end else begin
                  sh_l_r  <= q_item.first_pos;
                  sh_r_r  <= q_item.second_pos;
                  state_r <= BK_SH_L;
                end
              end
              MODE_LCP: begin
                if ((q_item.first_pos > len_r) || (q_item.second_pos > len_r)) begin
                  out_status_r <= ST_RANGE;
                  out_valid_r  <= 1'b1;
                end else if (q_item.fp_eq_sp) begin
                  out_mlen_r  <= len_r - q_item.first_pos;
                  out_valid_r <= 1'b1;
                end else begin
                  lo_r    <= '0;
                  hi_r    <= len_r - max_pos;
                  state_r <= BK_LCP;
                end
              end
              MODE_CLEAR: begin
                len_r       <= '0;
                out_valid_r <= 1'b1;
              end
              default: state_r <= BK_IDLE;
            endcase
          end
        end
        BK_APP_WT: state_r <= BK_APP_MUL;
        BK_APP_MUL: begin
          if (done_a) begin
            len_r       <= len_r + POS_W'(1);
            out_mlen_r  <= len_r + POS_W'(1);
            out_valid_r <= 1'b1;
            state_r     <= BK_IDLE;
          end
        end
        BK_LCP: begin
          if (lo_r < hi_r) begin
            mid_r   <= mid_sum[POS_W:1];
            sh_l_r  <= item_r.first_pos;
            sh_r_r  <= item_r.first_pos + mid_sum[POS_W:1];
            phase_r <= 1'b0;
            state_r <= BK_SH_L;
          end else begin
            out_mlen_r  <= lo_r;
            out_valid_r <= 1'b1;
            state_r     <= BK_IDLE;
          end
        end
        BK_SH_L: state_r <= BK_SH_R;
        BK_SH_R: begin
          pre_l_r <= pre_rd;
          pow_v_r <= pow_q_r;
          state_r <= BK_SH_GO;
        end
        BK_SH_GO: state_r <= BK_SH_MUL;
        BK_SH_MUL: begin
          if (done_a) begin
            if (item_r.mode == MODE_HASH) begin
              out_hash_r  <= {res_a, 1'b0, res_b};
              out_valid_r <= 1'b1;
              state_r     <= BK_IDLE;
            end else if (!phase_r) begin
              h1_r    <= mm_pair;
              sh_l_r  <= item_r.second_pos;
              sh_r_r  <= item_r.second_pos + mid_r;
              phase_r <= 1'b1;
              state_r <= BK_SH_L;
            end else begin
              if (h1_r == mm_pair) begin
                lo_r <= mid_r;
              end else begin
                hi_r <= mid_r - POS_W'(1);
              end
              state_r <= BK_LCP;
            end
          end
        end
        default: state_r <= BK_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/double_rolling_hash_lcp_core.sv
// top level: double-prime rolling hash over an appended byte string
// depends on drlh_pkg, drlh_front, drlh_queue, drlh_mulmod, drlh_back
// append, substring hash and lcp results come from the modular multipliers; lcp is a binary search,
// 17 steps at most, each hashing both substrings; clear, equal starts, range errors answer from idle
// one item at a time, taken only in idle once the previous result has been accepted
// reset: length cleared, power table built (65537 entries)
module double_rolling_hash_lcp_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // symbol[7:0], first_pos[24:8], second_pos[41:25]
  input  logic [1:0]  in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,   // hash_value[62:0], match_length[79:63]
  output logic [1:0]  out_tuser    // status
);
  import drlh_pkg::*;

  // front to queue
  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;

  // queue to back
  logic  qb_valid;
  logic  qb_pop;
  item_t qb_item;

  logic  fill_busy;

  // decode and classify incoming transfers
  drlh_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fill_busy (fill_busy),
    .q_ready   (fq_ready),
    .q_valid   (fq_valid),
    .q_item    (fq_item)
  );

  // short queue decoupling input side from the sequencer
  drlh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (qb_valid),
    .rd_pop   (qb_pop),
    .rd_item  (qb_item)
  );

  // stores, multipliers and result register
  drlh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_pop      (qb_pop),
    .q_item     (qb_item),
    .fill_busy  (fill_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
